@@ hw/rtl/dlr_pkg.sv @@
// Shared constants, types and fixed-point helpers for the DDA line rasterizer.
`default_nettype none

package dlr_pkg;

   // Coordinate and fixed-point geometry.
   localparam int COORD_BITS  = 6;
   localparam int FRAC_BITS   = 16;
   localparam int COLOUR_BITS = 8;

   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int POS_BITS   = COORD_BITS + 1;
   localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int SLOPE_BITS = FRAC_BITS + 2;
   localparam int PROD_BITS  = SLOPE_BITS + COORD_BITS;
   localparam int ACC_BITS   = FRAC_BITS + COORD_BITS + 3;
   localparam int ICPT_BITS  = COORD_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);

   localparam int COORD_MAX = (2 ** (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -(2 ** (COORD_BITS - 1));

   // Descriptor queue between the front and the back; depth is a power of two.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic        [COORD_BITS-1:0] mag_type;
   typedef logic        [COLOUR_BITS-1:0] colour_type;
   typedef logic signed [POS_BITS-1:0]   pos_type;
   typedef logic        [NUM_BITS-1:0]   num_type;
   typedef logic        [QUO_BITS-1:0]   quo_type;
   typedef logic signed [SLOPE_BITS-1:0] slope_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [ICPT_BITS-1:0]  icpt_type;
   typedef logic [DIV_CNT_BITS-1:0]      div_cnt_type;
   typedef logic [QUEUE_PTR_BITS-1:0]    queue_ptr_type;
   typedef logic [QUEUE_CNT_BITS-1:0]    queue_cnt_type;

   // One classified line, major axis ascending.
   typedef struct packed {
      logic       x_is_major;
      coord_type  lo_major;
      coord_type  hi_major;
      coord_type  hi_minor;
      mag_type    dmajor;
      logic       dminor_neg;
      mag_type    dminor_mag;
      colour_type colour;
   } line_desc_type;

   typedef struct packed {
      logic    start;
      num_type numerator;
      mag_type divisor;
   } div_req_type;

   typedef struct packed {
      logic    done;
      quo_type quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_SLOPE,
      BK_MUL_HI,
      BK_ICPT,
      BK_SEED,
      BK_DRAW
   } back_state_type;

   // Drop the fraction, rounding toward zero.
   function automatic acc_type trunc_frac(acc_type value);
      acc_type magnitude;
      acc_type shifted;
      magnitude = value[ACC_BITS-1] ? -value : value;
      shifted   = magnitude >>> FRAC_BITS;
      return value[ACC_BITS-1] ? -shifted : shifted;
   endfunction

   // Clamp an integer to the signed coordinate range.
   function automatic coord_type sat_coord(acc_type value);
      coord_type result;
      if (value > acc_type'(COORD_MAX)) begin
         result = coord_type'(COORD_MAX);
      end else if (value < acc_type'(COORD_MIN)) begin
         result = coord_type'(COORD_MIN);
      end else begin
         result = coord_type'(value);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dlr_front.sv @@
// Front end: accepts line requests and classifies them into queue descriptors.
`default_nettype none

module dlr_front (
   input  wire logic                   start,
   input  wire dlr_pkg::coord_type     req_start_x,
   input  wire dlr_pkg::coord_type     req_start_y,
   input  wire dlr_pkg::coord_type     req_finish_x,
   input  wire dlr_pkg::coord_type     req_finish_y,
   input  wire dlr_pkg::colour_type    req_colour,
   input  wire logic                   queue_full,
   output logic                        busy,
   output logic                        push,
   output dlr_pkg::line_desc_type      desc
);

   dlr_pkg::delta_type dx;
   dlr_pkg::delta_type dy;
   dlr_pkg::delta_type dminor;
   dlr_pkg::mag_type   abs_dx;
   dlr_pkg::mag_type   abs_dy;
   logic               x_major;
   logic               swap;
   dlr_pkg::coord_type a_major;
   dlr_pkg::coord_type a_minor;
   dlr_pkg::coord_type b_major;
   dlr_pkg::coord_type b_minor;
   dlr_pkg::coord_type lo_major;
   dlr_pkg::coord_type lo_minor;
   dlr_pkg::coord_type hi_major;
   dlr_pkg::coord_type hi_minor;

   assign busy = queue_full;
   assign push = start & ~queue_full;

   always_comb begin
      dx = dlr_pkg::delta_type'(req_finish_x) - dlr_pkg::delta_type'(req_start_x);
      dy = dlr_pkg::delta_type'(req_finish_y) - dlr_pkg::delta_type'(req_start_y);
      abs_dx = dx[dlr_pkg::DELTA_BITS-1] ? dlr_pkg::mag_type'(-dx) : dlr_pkg::mag_type'(dx);
      abs_dy = dy[dlr_pkg::DELTA_BITS-1] ? dlr_pkg::mag_type'(-dy) : dlr_pkg::mag_type'(dy);

      // A flat line (including a single point) runs along x; a tie goes to y.
      if (dy == '0) begin
         x_major = 1'b1;
      end else if (dx == '0) begin
         x_major = 1'b0;
      end else begin
         x_major = abs_dx > abs_dy;
      end

      a_major = x_major ? req_start_x  : req_start_y;
      a_minor = x_major ? req_start_y  : req_start_x;
      b_major = x_major ? req_finish_x : req_finish_y;
      b_minor = x_major ? req_finish_y : req_finish_x;

      swap     = a_major > b_major;
      lo_major = swap ? b_major : a_major;
      lo_minor = swap ? b_minor : a_minor;
      hi_major = swap ? a_major : b_major;
      hi_minor = swap ? a_minor : b_minor;

      dminor = dlr_pkg::delta_type'(hi_minor) - dlr_pkg::delta_type'(lo_minor);

      desc.x_is_major = x_major;
      desc.lo_major   = lo_major;
      desc.hi_major   = hi_major;
      desc.hi_minor   = hi_minor;
      desc.dmajor     = dlr_pkg::mag_type'(dlr_pkg::delta_type'(hi_major)
                                           - dlr_pkg::delta_type'(lo_major));
      desc.dminor_neg = dminor[dlr_pkg::DELTA_BITS-1];
      desc.dminor_mag = dminor[dlr_pkg::DELTA_BITS-1] ? dlr_pkg::mag_type'(-dminor)
                                                      : dlr_pkg::mag_type'(dminor);
      desc.colour     = req_colour;
   end

endmodule

`default_nettype wire

@@ hw/rtl/dlr_queue.sv @@
// Short descriptor queue that decouples the front end from the drawing engine.
`default_nettype none

module dlr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dlr_pkg::line_desc_type push_desc,
   input  wire logic                   pop,
   output dlr_pkg::line_desc_type      head_desc,
   output logic                        full,
   output logic                        empty
);

   dlr_pkg::line_desc_type  entry_ff [dlr_pkg::QUEUE_DEPTH];
   dlr_pkg::queue_ptr_type  wr_ptr_ff;
   dlr_pkg::queue_ptr_type  wr_ptr_in;
   dlr_pkg::queue_ptr_type  rd_ptr_ff;
   dlr_pkg::queue_ptr_type  rd_ptr_in;
   dlr_pkg::queue_cnt_type  count_ff;
   dlr_pkg::queue_cnt_type  count_in;

   assign full      = count_ff == dlr_pkg::queue_cnt_type'(dlr_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/dlr_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the line slope.
`default_nettype none

module dlr_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dlr_pkg::div_req_type div_req,
   output dlr_pkg::div_rsp_type      div_rsp
);

   dlr_pkg::num_type     num_ff;
   dlr_pkg::num_type     num_in;
   dlr_pkg::mag_type     rem_ff;
   dlr_pkg::mag_type     rem_in;
   dlr_pkg::mag_type     divisor_ff;
   dlr_pkg::div_cnt_type cnt_ff;
   dlr_pkg::div_cnt_type cnt_in;
   logic                 running_ff;
   logic                 running_in;
   logic                 done_ff;
   logic                 done_in;
   logic [dlr_pkg::COORD_BITS:0] rem_shift;
   logic                 fits;

   // The numerator register fills with quotient bits as it shifts out.
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff[dlr_pkg::QUO_BITS-1:0];

   always_comb begin
      rem_shift  = {rem_ff, num_ff[dlr_pkg::NUM_BITS-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      num_in     = num_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = '0;
         num_in     = div_req.numerator;
         cnt_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         rem_in = fits ? dlr_pkg::mag_type'(rem_shift - {1'b0, divisor_ff})
                       : dlr_pkg::mag_type'(rem_shift);
         num_in = {num_ff[dlr_pkg::NUM_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dlr_pkg::div_cnt_type'(dlr_pkg::NUM_BITS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (div_req.start) begin
         divisor_ff <= div_req.divisor;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/dlr_back.sv @@
// Drawing engine: slope and intercept setup, then one pixel beat per cycle.
`default_nettype none

module dlr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   queue_empty,
   input  wire dlr_pkg::line_desc_type queue_head,
   output logic                        pop,
   output dlr_pkg::div_req_type        div_req,
   input  wire dlr_pkg::div_rsp_type   div_rsp,
   output logic                        rsp_strobe,
   output dlr_pkg::coord_type          rsp_pixel_x,
   output dlr_pkg::coord_type          rsp_pixel_y,
   output dlr_pkg::colour_type         rsp_pixel_colour,
   output logic                        rsp_last_pixel
);

   dlr_pkg::back_state_type state_ff;
   dlr_pkg::back_state_type state_in;
   dlr_pkg::line_desc_type  desc_ff;
   dlr_pkg::line_desc_type  desc_in;
   dlr_pkg::slope_type      slope_ff;
   dlr_pkg::slope_type      slope_in;
   dlr_pkg::prod_type       prod_ff;
   dlr_pkg::prod_type       prod_in;
   dlr_pkg::icpt_type       intercept_ff;
   dlr_pkg::icpt_type       intercept_in;
   dlr_pkg::acc_type        acc_ff;
   dlr_pkg::acc_type        acc_in;
   dlr_pkg::pos_type        pos_ff;
   dlr_pkg::pos_type        pos_in;

   logic                    rsp_strobe_ff;
   logic                    rsp_strobe_in;
   dlr_pkg::coord_type      rsp_pixel_x_ff;
   dlr_pkg::coord_type      rsp_pixel_x_in;
   dlr_pkg::coord_type      rsp_pixel_y_ff;
   dlr_pkg::coord_type      rsp_pixel_y_in;
   dlr_pkg::colour_type     rsp_colour_ff;
   dlr_pkg::colour_type     rsp_colour_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;

   dlr_pkg::coord_type      lo_major;
   dlr_pkg::coord_type      hi_major;
   dlr_pkg::coord_type      hi_minor;
   dlr_pkg::coord_type      mul_operand;
   dlr_pkg::prod_type       product;
   dlr_pkg::coord_type      minor;
   dlr_pkg::coord_type      major;
   logic                    at_end;

   assign lo_major = desc_ff.lo_major;
   assign hi_major = desc_ff.hi_major;
   assign hi_minor = desc_ff.hi_minor;

   // The single multiplier serves both setup products.
   assign mul_operand = (state_ff == dlr_pkg::BK_MUL_HI) ? hi_major : lo_major;
   assign product     = dlr_pkg::prod_type'(slope_ff) * dlr_pkg::prod_type'(mul_operand);

   assign minor  = dlr_pkg::sat_coord(dlr_pkg::trunc_frac(acc_ff));
   assign major  = dlr_pkg::coord_type'(pos_ff);
   assign at_end = pos_ff >= dlr_pkg::pos_type'(hi_major);

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_pixel_x      = rsp_pixel_x_ff;
   assign rsp_pixel_y      = rsp_pixel_y_ff;
   assign rsp_pixel_colour = rsp_colour_ff;
   assign rsp_last_pixel   = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dlr_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = dlr_pkg::BK_DIVIDE;
            end
         end
         dlr_pkg::BK_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = dlr_pkg::BK_SLOPE;
            end
         end
         dlr_pkg::BK_SLOPE:  state_in = dlr_pkg::BK_MUL_HI;
         dlr_pkg::BK_MUL_HI: state_in = dlr_pkg::BK_ICPT;
         dlr_pkg::BK_ICPT:   state_in = dlr_pkg::BK_SEED;
         dlr_pkg::BK_SEED:   state_in = dlr_pkg::BK_DRAW;
         dlr_pkg::BK_DRAW: begin
            if (at_end) begin
               state_in = dlr_pkg::BK_IDLE;
            end
         end
         default: state_in = dlr_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop               = 1'b0;
      div_req.start     = 1'b0;
      div_req.numerator = {queue_head.dminor_mag, {dlr_pkg::FRAC_BITS{1'b0}}};
      div_req.divisor   = queue_head.dmajor;
      desc_in           = desc_ff;
      slope_in          = slope_ff;
      prod_in           = prod_ff;
      intercept_in      = intercept_ff;
      acc_in            = acc_ff;
      pos_in            = pos_ff;
      rsp_strobe_in     = 1'b0;
      rsp_pixel_x_in    = rsp_pixel_x_ff;
      rsp_pixel_y_in    = rsp_pixel_y_ff;
      rsp_colour_in     = rsp_colour_ff;
      rsp_last_in       = rsp_last_ff;
      unique case (state_ff)
         dlr_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               pop           = 1'b1;
               div_req.start = 1'b1;
               desc_in       = queue_head;
            end
         end
         dlr_pkg::BK_SLOPE: begin
            // A single point has no major extent and a flat slope.
            if (desc_ff.dmajor == '0) begin
               slope_in = '0;
            end else if (desc_ff.dminor_neg) begin
               slope_in = -dlr_pkg::slope_type'(div_rsp.quotient);
            end else begin
               slope_in = dlr_pkg::slope_type'(div_rsp.quotient);
            end
         end
         dlr_pkg::BK_MUL_HI: begin
            prod_in = product;
         end
         dlr_pkg::BK_ICPT: begin
            intercept_in = dlr_pkg::icpt_type'(dlr_pkg::trunc_frac(
               (dlr_pkg::acc_type'(hi_minor) <<< dlr_pkg::FRAC_BITS)
               - dlr_pkg::acc_type'(prod_ff)));
            prod_in = product;
         end
         dlr_pkg::BK_SEED: begin
            acc_in = (dlr_pkg::acc_type'(intercept_ff) <<< dlr_pkg::FRAC_BITS)
                     + dlr_pkg::acc_type'(prod_ff);
            pos_in = dlr_pkg::pos_type'(lo_major);
         end
         dlr_pkg::BK_DRAW: begin
            rsp_strobe_in  = 1'b1;
            rsp_pixel_x_in = desc_ff.x_is_major ? major : minor;
            rsp_pixel_y_in = desc_ff.x_is_major ? minor : major;
            rsp_colour_in  = desc_ff.colour;
            rsp_last_in    = at_end;
            pos_in         = pos_ff + dlr_pkg::pos_type'(1);
            acc_in         = acc_ff + dlr_pkg::acc_type'(slope_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dlr_pkg::BK_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff        <= desc_in;
      slope_ff       <= slope_in;
      prod_ff        <= prod_in;
      intercept_ff   <= intercept_in;
      acc_ff         <= acc_in;
      pos_ff         <= pos_in;
      rsp_pixel_x_ff <= rsp_pixel_x_in;
      rsp_pixel_y_ff <= rsp_pixel_y_in;
      rsp_colour_ff  <= rsp_colour_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/dda_line_rasterizer_unit.sv @@
// Top level of the DDA line rasterizer: front end, descriptor queue, divider, drawing engine.
//
//   Channel   Ports                                         Beat taken when
//   -------   -------------------------------------------   ----------------------------
//   request   start, busy, req_start_x/y, req_finish_x/y,    rising edge, start & !busy
//             req_colour
//   result    rsp_strobe, rsp_pixel_x/y, rsp_pixel_colour,   rising edge ending the cycle
//             rsp_last_pixel                                 in which rsp_strobe is high
//
// For each line the engine first runs the bit-serial slope division, then forms the intercept
// and seed products on the shared multiplier, and then emits one pixel beat every cycle with
// no gaps until the last pixel.
// Reset is synchronous and active high; it empties the queue and idles the engine.
// The result side cannot stall. The request side stalls (busy high) only when the
// two-entry descriptor queue is full, so up to two lines can wait behind the one being
// drawn.
//
// The front end classifies each request as it is accepted: it picks the major axis,
// orders the end points so the major coordinate ascends, and records the deltas. The
// drawing engine then forms slope = minor delta / major delta in Q.16, truncated toward
// zero, and the intercept trunc(end_minor - slope * end_major). Instead of a multiply
// per pixel, it seeds an accumulator with intercept + slope * first_major and adds the
// slope once per step; the integer accumulator gives exactly the same value as the
// direct product. Each minor coordinate is the accumulator truncated toward zero and
// saturated to the signed coordinate range.
`default_nettype none

module dda_line_rasterizer_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire dlr_pkg::coord_type  req_start_x,
   input  wire dlr_pkg::coord_type  req_start_y,
   input  wire dlr_pkg::coord_type  req_finish_x,
   input  wire dlr_pkg::coord_type  req_finish_y,
   input  wire dlr_pkg::colour_type req_colour,
   output logic                     rsp_strobe,
   output dlr_pkg::coord_type       rsp_pixel_x,
   output dlr_pkg::coord_type       rsp_pixel_y,
   output dlr_pkg::colour_type      rsp_pixel_colour,
   output logic                     rsp_last_pixel
);

   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_empty;
   dlr_pkg::line_desc_type push_desc;
   dlr_pkg::line_desc_type head_desc;
   dlr_pkg::div_req_type   div_req;
   dlr_pkg::div_rsp_type   div_rsp;

   // Classification happens in the same cycle the request beat is taken.
   dlr_front u_front (
      .start        (start),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_finish_x (req_finish_x),
      .req_finish_y (req_finish_y),
      .req_colour   (req_colour),
      .queue_full   (queue_full),
      .busy         (busy),
      .push         (push),
      .desc         (push_desc)
   );

   // The queue lets new requests land while the engine is still drawing.
   dlr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // One slope division per line, started as the engine pops a descriptor.
   dlr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dlr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_head       (head_desc),
      .pop              (pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire

@@ hw/rtl/dlr_checker.sv @@
// Port-level checks for the DDA line rasterizer, bound to the top level.
`default_nettype none

module dlr_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                busy,
   input wire logic                rsp_strobe,
   input wire dlr_pkg::coord_type  rsp_pixel_x,
   input wire dlr_pkg::coord_type  rsp_pixel_y,
   input wire dlr_pkg::colour_type rsp_pixel_colour,
   input wire logic                rsp_last_pixel
);

   // After reset nothing is in flight and requests are welcome.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("pixel beat or busy right after reset");

   // Pixels of one line come out in consecutive cycles.
   a_line_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_pixel) |=> rsp_strobe)
      else $error("gap inside a line");

   // A line keeps its colour from first to last pixel.
   a_colour_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_pixel) |=> (rsp_pixel_colour == $past(rsp_pixel_colour)))
      else $error("colour changed inside a line");

   // Along a line one axis steps up by exactly one each beat.
   a_major_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_pixel) |=>
         ((rsp_pixel_x == $past(rsp_pixel_x) + dlr_pkg::coord_type'(1))
          || (rsp_pixel_y == $past(rsp_pixel_y) + dlr_pkg::coord_type'(1))))
      else $error("major coordinate did not advance by one");

endmodule

bind dda_line_rasterizer_unit dlr_checker u_checker (.*);

`default_nettype wire

@@ test/tb_dda_line_rasterizer_unit.sv @@
// Self-checking testbench for the DDA line rasterizer: directed and random lines.

module tb_dda_line_rasterizer_unit;

   // The slowest line is 64 pixels plus the slope division and seeding, so the 160 random
   // lines with gaps finish well inside this limit.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_LINES = 160;
   localparam int STEADY_LINES = 30;
   localparam int TAIL_CYCLES  = 40;
   localparam int ONE_Q        = 1 << dlr_pkg::FRAC_BITS;
   localparam int REPORT_LIMIT = 10;

   // One pixel beat as it appears on the result ports.
   typedef struct packed {
      dlr_pkg::coord_type  x;
      dlr_pkg::coord_type  y;
      dlr_pkg::colour_type colour;
      logic                last;
   } pixel_type;

   // One line request. A point row is a single pixel whose result is read straight off
   // the row instead of coming from the predictor.
   typedef struct {
      int sx;
      int sy;
      int fx;
      int fy;
      int colour;
      bit point;
   } line_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   dlr_pkg::coord_type  req_start_x = '0;
   dlr_pkg::coord_type  req_start_y = '0;
   dlr_pkg::coord_type  req_finish_x = '0;
   dlr_pkg::coord_type  req_finish_y = '0;
   dlr_pkg::colour_type req_colour = '0;
   logic                rsp_strobe;
   dlr_pkg::coord_type  rsp_pixel_x;
   dlr_pkg::coord_type  rsp_pixel_y;
   dlr_pkg::colour_type rsp_pixel_colour;
   logic                rsp_last_pixel;

   pixel_type expected_pixels[$];
   pixel_type got_pixel;
   pixel_type want_pixel;
   int        mismatch_count = 0;
   int        pixel_beats = 0;
   int        cycle_count = 0;

   // Directed lines: columns are start x, start y, finish x, finish y, colour, point.
   line_req_type directed_lines[22] = '{
      '{0, 0, 0, 0, 8'h00, 1'b1},          // single point at the origin
      '{-32, -32, -32, -32, 8'hFF, 1'b1},  // single point at the lowest corner
      '{31, 31, 31, 31, 8'hA5, 1'b1},      // single point at the highest corner
      '{-32, 31, -32, 31, 8'h5A, 1'b1},    // single point at a mixed corner
      '{-32, 5, 31, 5, 8'h01, 1'b0},       // full-width horizontal, 64 pixels
      '{31, -7, -32, -7, 8'h80, 1'b0},     // horizontal drawn right to left
      '{3, -32, 3, 31, 8'h7F, 1'b0},       // full-height vertical
      '{-4, 31, -4, -32, 8'hFE, 1'b0},     // vertical drawn top to bottom
      '{-32, -32, 31, 31, 8'h33, 1'b0},    // main diagonal, a tie makes y major
      '{-32, 31, 31, -32, 8'hCC, 1'b0},    // anti-diagonal
      '{31, -32, -32, 31, 8'h0F, 1'b0},    // anti-diagonal, ends swapped
      '{-32, 0, 31, 1, 8'hF0, 1'b0},       // shallowest positive slope
      '{0, -32, 1, 31, 8'h55, 1'b0},       // steepest y-major line
      '{-32, 0, 31, -1, 8'hAA, 1'b0},      // shallowest negative slope
      '{0, 31, 1, -32, 8'h3C, 1'b0},       // steep line with falling x
      '{0, 0, 1, 1, 8'hC3, 1'b0},
      '{-1, -1, 0, 0, 8'h96, 1'b0},
      '{0, 0, -1, 1, 8'h69, 1'b0},
      '{-20, -3, 17, 10, 8'h12, 1'b0},     // truncation with mixed-sign minor values
      '{-5, -9, 11, -14, 8'h34, 1'b0},
      '{7, -20, -6, 25, 8'h56, 1'b0},
      '{-32, -32, 31, -31, 8'h78, 1'b0}    // minor axis hugging the lower bound
   };

   always #1 clock = ~clock;

   dda_line_rasterizer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_finish_x     (req_finish_x),
      .req_finish_y     (req_finish_y),
      .req_colour       (req_colour),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // Rasterizes one line the way the block should and queues every pixel it must emit.
   // The major axis is x for horizontal lines and points, y for vertical lines, and
   // otherwise the longer axis with y winning a tie. Integer division in SystemVerilog
   // truncates toward zero, which is exactly the rounding the fixed-point slope, the
   // intercept and each minor coordinate need.
   function automatic void trace_line(input line_req_type l);
      int        dx;
      int        dy;
      int        lo_major;
      int        lo_minor;
      int        hi_major;
      int        hi_minor;
      int        swap;
      int        slope;
      int        icpt;
      int        minor;
      int        pos;
      bit        x_major;
      pixel_type pix;
      dx = l.fx - l.sx;
      dy = l.fy - l.sy;
      if (dy == 0) begin
         x_major = 1'b1;
      end else if (dx == 0) begin
         x_major = 1'b0;
      end else begin
         x_major = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
      end
      if (x_major) begin
         lo_major = l.sx;
         lo_minor = l.sy;
         hi_major = l.fx;
         hi_minor = l.fy;
      end else begin
         lo_major = l.sy;
         lo_minor = l.sx;
         hi_major = l.fy;
         hi_minor = l.fx;
      end
      // Order the end points so that the major coordinate ascends.
      if (lo_major > hi_major) begin
         swap = lo_major;
         lo_major = hi_major;
         hi_major = swap;
         swap = lo_minor;
         lo_minor = hi_minor;
         hi_minor = swap;
      end
      slope = (hi_major != lo_major) ?
              (hi_minor - lo_minor) * ONE_Q / (hi_major - lo_major) : 0;
      icpt = (hi_minor * ONE_Q - slope * hi_major) / ONE_Q;
      for (pos = lo_major; pos <= hi_major; pos++) begin
         minor = (icpt * ONE_Q + slope * pos) / ONE_Q;
         // The minor coordinate saturates to the signed coordinate range.
         if (minor > dlr_pkg::COORD_MAX) begin
            minor = dlr_pkg::COORD_MAX;
         end else if (minor < dlr_pkg::COORD_MIN) begin
            minor = dlr_pkg::COORD_MIN;
         end
         pix.x      = dlr_pkg::coord_type'(x_major ? pos : minor);
         pix.y      = dlr_pkg::coord_type'(x_major ? minor : pos);
         pix.colour = dlr_pkg::colour_type'(l.colour);
         pix.last   = (pos == hi_major);
         expected_pixels.push_back(pix);
      end
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(dlr_pkg::COORD_MAX - dlr_pkg::COORD_MIN, 0))
             + dlr_pkg::COORD_MIN;
   endfunction

   // A coordinate within eight of the given one, clamped to the legal range.
   function automatic int near_coord(input int c);
      int t;
      t = c + int'($urandom_range(16, 0)) - 8;
      if (t > dlr_pkg::COORD_MAX) begin
         t = dlr_pkg::COORD_MAX;
      end else if (t < dlr_pkg::COORD_MIN) begin
         t = dlr_pkg::COORD_MIN;
      end
      return t;
   endfunction

   // Random lines: a mix of short ones, points, axis-aligned lines, diagonals and
   // lines across the whole plane.
   function automatic line_req_type random_line();
      line_req_type l;
      int           d;
      l.sx     = rand_coord();
      l.sy     = rand_coord();
      l.colour = int'($urandom_range(255, 0));
      l.point  = 1'b0;
      case ($urandom_range(9, 0)) inside
         0: begin
            l.fx = l.sx;
            l.fy = l.sy;
         end
         1: begin
            l.fx = rand_coord();
            l.fy = l.sy;
         end
         2: begin
            l.fx = l.sx;
            l.fy = rand_coord();
         end
         3: begin
            // Keep both ends in range while the two deltas have equal magnitude.
            l.sx = int'($urandom_range(31, 0)) - 16;
            l.sy = int'($urandom_range(31, 0)) - 16;
            d    = int'($urandom_range(31, 0)) - 16;
            l.fx = l.sx + d;
            l.fy = $urandom_range(1, 0) ? l.sy + d : l.sy - d;
         end
         [4:6]: begin
            l.fx = near_coord(l.sx);
            l.fy = near_coord(l.sy);
         end
         default: begin
            l.fx = rand_coord();
            l.fy = rand_coord();
         end
      endcase
      return l;
   endfunction

   task automatic flag_error(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("ERROR at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Presents one line at the falling edge and holds it until a rising edge sees start
   // high with busy low. The pixels it owes are queued at that edge. Since start is only
   // ever set here and in idle_for, a line that follows straight on keeps start high.
   task automatic send_line(input line_req_type l);
      @(negedge clock);
      start        = 1'b1;
      req_start_x  = dlr_pkg::coord_type'(l.sx);
      req_start_y  = dlr_pkg::coord_type'(l.sy);
      req_finish_x = dlr_pkg::coord_type'(l.fx);
      req_finish_y = dlr_pkg::coord_type'(l.fy);
      req_colour   = dlr_pkg::colour_type'(l.colour);
      do begin
         @(posedge clock);
      end while (busy);
      if (l.point) begin
         expected_pixels.push_back('{x: dlr_pkg::coord_type'(l.sx),
                                     y: dlr_pkg::coord_type'(l.sy),
                                     colour: dlr_pkg::colour_type'(l.colour),
                                     last: 1'b1});
      end else begin
         trace_line(l);
      end
   endtask

   // Drops start for the given number of cycles. The request fields carry noise while
   // start is low, and the block must ignore it.
   task automatic idle_for(input int cycles);
      @(negedge clock);
      start        = 1'b0;
      req_start_x  = dlr_pkg::coord_type'($urandom);
      req_start_y  = dlr_pkg::coord_type'($urandom);
      req_finish_x = dlr_pkg::coord_type'($urandom);
      req_finish_y = dlr_pkg::coord_type'($urandom);
      req_colour   = dlr_pkg::colour_type'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Holds the request side quiet until every queued pixel has come back.
   task automatic drain_lines();
      idle_for(1);
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Every pixel beat is checked at the rising edge that takes it, against the oldest
   // pixel still owed. The result side cannot stall, so there is no back-pressure here.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_pixel = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_colour, rsp_last_pixel};
         if (expected_pixels.size() == 0) begin
            flag_error($sformatf("pixel beat %0d with none owed: x=%0d y=%0d colour=%0h last=%0b",
                                 pixel_beats, got_pixel.x, got_pixel.y, got_pixel.colour,
                                 got_pixel.last));
         end else begin
            want_pixel = expected_pixels.pop_front();
            if (got_pixel !== want_pixel) begin
               flag_error($sformatf({"pixel beat %0d: expected x=%0d y=%0d colour=%0h last=%0b,",
                                     " got x=%0d y=%0d colour=%0h last=%0b"},
                                    pixel_beats, want_pixel.x, want_pixel.y, want_pixel.colour,
                                    want_pixel.last, got_pixel.x, got_pixel.y,
                                    got_pixel.colour, got_pixel.last));
            end
         end
         pixel_beats++;
      end
   end

   // A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int burst_left;
      int i;
      burst_left = 0;
      // Synchronous reset, held from time zero and released at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lines, with an occasional short gap between them.
      foreach (directed_lines[n]) begin
         send_line(directed_lines[n]);
         if ($urandom_range(3, 0) == 0) begin
            idle_for($urandom_range(5, 1));
         end
      end
      drain_lines();

      // Random lines. The first stretch runs back to back so the two-entry queue fills
      // and busy is exercised; after that the sender works in bursts with random gaps,
      // and every fifty lines it waits for the block to drain completely.
      for (i = 0; i < RANDOM_LINES; i++) begin
         if (i >= STEADY_LINES) begin
            if (burst_left == 0) begin
               idle_for($urandom_range(12, 1));
               burst_left = $urandom_range(10, 1);
            end
            burst_left--;
         end
         if (i % 50 == 49) begin
            drain_lines();
         end
         send_line(random_line());
      end

      // Wait for the last pixel, then a little longer to catch any stray beats.
      drain_lines();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
